@@ hw/rtl/rms_pkg.sv @@
package rms_pkg;

  localparam int CAPACITY   = 1024;
  localparam int SAMPLE_W   = 32;
  localparam int MED_W      = 33;
  localparam int COUNT_W    = 11;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int GRP_SIZE   = 32;
  localparam int GRP_W      = $clog2(GRP_SIZE);
  localparam int NGROUP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NGRP_W     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
  localparam int SEL_W      = NGRP_W + GRP_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - MED_W - COUNT_W - 1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic in_tready;
    logic grp_en;
    logic out_load;
  } ctrl_t;

endpackage

@@ hw/rtl/rms_cell.sv @@
module rms_cell (
  input  logic                                 clk,
  input  logic                                 ins,
  input  rms_pkg::sample_t                     sample,
  input  logic             [rms_pkg::IDX_W-1:0] idx,
  input  logic             [rms_pkg::CNT_W-1:0] eff_cnt,
  input  rms_pkg::sample_t                     left_val,
  input  logic                                 left_gt,
  output rms_pkg::sample_t                     val,
  output logic                                 gt
);

  rms_pkg::sample_t val_r;
  rms_pkg::sample_t val_nxt;
  logic             occ;

  // cell holds a stored sample when its place is below the count
  assign occ = rms_pkg::CNT_W'(idx) < eff_cnt;
  assign gt  = occ && (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (left_gt) begin
      val_nxt = left_val;
    end else if (gt || !occ) begin
      val_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      val_r <= val_nxt;
    end
  end

endmodule

@@ hw/rtl/rms_grp.sv @@
module rms_grp (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic             [rms_pkg::NGRP_W-1:0] grp,
  input  logic             [rms_pkg::SEL_W-1:0]  lo_idx,
  input  logic             [rms_pkg::SEL_W-1:0]  hi_idx,
  input  rms_pkg::sample_t                      vals [rms_pkg::GRP_SIZE],
  output rms_pkg::sample_t                      lo_val,
  output rms_pkg::sample_t                      hi_val
);

  rms_pkg::sample_t lo_r, lo_nxt;
  rms_pkg::sample_t hi_r, hi_nxt;
  logic             lo_in_grp, hi_in_grp;

  assign lo_in_grp = lo_idx[rms_pkg::SEL_W-1:rms_pkg::GRP_W] == grp;
  assign hi_in_grp = hi_idx[rms_pkg::SEL_W-1:rms_pkg::GRP_W] == grp;

  // and-or select, zero when the index lies in another group
  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int j = 0; j < rms_pkg::GRP_SIZE; j++) begin
      if (lo_in_grp && (lo_idx[rms_pkg::GRP_W-1:0] == rms_pkg::GRP_W'(j))) begin
        lo_nxt = lo_nxt | vals[j];
      end
      if (hi_in_grp && (hi_idx[rms_pkg::GRP_W-1:0] == rms_pkg::GRP_W'(j))) begin
        hi_nxt = hi_nxt | vals[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign lo_val = lo_r;
  assign hi_val = hi_r;

endmodule

@@ hw/rtl/rms_ctl.sv @@
module rms_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           out_valid,
  input  logic           out_tready,
  output rms_pkg::ctrl_t ctrl
);

  rms_pkg::state_t state_r, state_nxt;
  logic            out_free;

  assign out_free = !out_valid || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rms_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rms_pkg::ST_GRP;
        end
      end
      rms_pkg::ST_GRP: begin
        state_nxt = rms_pkg::ST_FIN;
      end
      rms_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = in_tvalid ? rms_pkg::ST_GRP : rms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rms_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_r)
      rms_pkg::ST_IDLE: begin
        ctrl.in_tready = 1'b1;
      end
      rms_pkg::ST_GRP: begin
        ctrl.grp_en = 1'b1;
      end
      rms_pkg::ST_FIN: begin
        ctrl.out_load  = out_free;
        ctrl.in_tready = out_free;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/running_median_stream.sv @@
// channel | direction | tdata (low bit up)                          | tuser
// in_     | input     | sample[31:0]                                | first
// out_    | output    | median_twice[32:0] count[43:33] overflow[44] | -
//
// per item: an insert shifts the sample into the sorted cell chain, then the
// group step registers the two middle cells through 32-cell group muxes
// the final mux and add overlap the next insert
// reset empties the chain by clearing the count, no clearing pass
// a result held at the output stalls the final stage and with it the input
module running_median_stream (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rms_pkg::IN_DATA_W-1:0]    in_tdata,   // sample
  input  logic                             in_tuser,   // first
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rms_pkg::OUT_DATA_W-1:0]   out_tdata   // median_twice, count, overflow
);

  localparam int PAD_CELLS = rms_pkg::NGROUP * rms_pkg::GRP_SIZE;

  rms_pkg::ctrl_t   ctrl;
  rms_pkg::sample_t sample;
  logic             accept;
  logic             ins;
  logic             full;

  logic [rms_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [rms_pkg::CNT_W-1:0] eff_cnt;
  logic                      ovf_r;
  logic [rms_pkg::CNT_W-1:0] p_cnt_r;
  logic                      p_ovf_r;
  logic [rms_pkg::SEL_W-1:0] hi_idx, lo_idx;

  rms_pkg::sample_t cell_val [PAD_CELLS];
  logic             cell_gt  [rms_pkg::CAPACITY];

  rms_pkg::sample_t grp_lo [rms_pkg::NGROUP];
  rms_pkg::sample_t grp_hi [rms_pkg::NGROUP];
  rms_pkg::sample_t lo_all, hi_all;

  logic signed [rms_pkg::MED_W-1:0] med_nxt;
  logic signed [rms_pkg::MED_W-1:0] med_r;
  logic [rms_pkg::COUNT_W-1:0]      cnt_out_r;
  logic                             ovf_out_r;
  logic                             out_valid_r;

  rms_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .out_valid (out_valid_r),
    .out_tready(out_tready),
    .ctrl      (ctrl)
  );

  assign in_tready = ctrl.in_tready;
  assign accept    = in_tvalid && ctrl.in_tready;
  assign sample    = rms_pkg::sample_t'(in_tdata[rms_pkg::SAMPLE_W-1:0]);
  assign eff_cnt   = in_tuser ? '0 : count_r;
  assign full      = eff_cnt >= rms_pkg::CNT_W'(rms_pkg::CAPACITY);
  assign ins       = accept && !full;
  assign count_nxt = ins ? eff_cnt + rms_pkg::CNT_W'(1) : eff_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ovf_r <= full;
    end
    if (ctrl.grp_en) begin
      p_cnt_r <= count_r;
      p_ovf_r <= ovf_r;
    end
  end

  for (genvar i = 0; i < rms_pkg::CAPACITY; i++) begin : g_cell
    rms_pkg::sample_t left_val;
    logic             left_gt;
    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    rms_cell u_cell (
      .clk     (clk),
      .ins     (ins),
      .sample  (sample),
      .idx     (rms_pkg::IDX_W'(i)),
      .eff_cnt (eff_cnt),
      .left_val(left_val),
      .left_gt (left_gt),
      .val     (cell_val[i]),
      .gt      (cell_gt[i])
    );
  end

  for (genvar i = rms_pkg::CAPACITY; i < PAD_CELLS; i++) begin : g_pad
    assign cell_val[i] = '0;
  end

  // middle places: count/2, and count/2-1 when the count is even
  assign hi_idx = rms_pkg::SEL_W'(count_r >> 1);
  assign lo_idx = count_r[0] ? hi_idx : hi_idx - rms_pkg::SEL_W'(1);

  for (genvar g = 0; g < rms_pkg::NGROUP; g++) begin : g_grp
    rms_pkg::sample_t vals [rms_pkg::GRP_SIZE];
    for (genvar j = 0; j < rms_pkg::GRP_SIZE; j++) begin : g_tap
      assign vals[j] = cell_val[g * rms_pkg::GRP_SIZE + j];
    end
    rms_grp u_grp (
      .clk   (clk),
      .en    (ctrl.grp_en),
      .grp   (rms_pkg::NGRP_W'(g)),
      .lo_idx(lo_idx),
      .hi_idx(hi_idx),
      .vals  (vals),
      .lo_val(grp_lo[g]),
      .hi_val(grp_hi[g])
    );
  end

  always_comb begin
    lo_all = '0;
    hi_all = '0;
    for (int g = 0; g < rms_pkg::NGROUP; g++) begin
      lo_all = lo_all | grp_lo[g];
      hi_all = hi_all | grp_hi[g];
    end
  end

  assign med_nxt = {lo_all[rms_pkg::SAMPLE_W-1], lo_all}
                 + {hi_all[rms_pkg::SAMPLE_W-1], hi_all};

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      med_r     <= med_nxt;
      cnt_out_r <= rms_pkg::COUNT_W'(p_cnt_r);
      ovf_out_r <= p_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{rms_pkg::OUT_PAD_W{1'b0}}, ovf_out_r, cnt_out_r, med_r};

endmodule

@@ hw/rtl/rms_chk.sv @@
module rms_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [rms_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [rms_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CNT_LO = rms_pkg::MED_W;
  localparam int CNT_HI = rms_pkg::MED_W + rms_pkg::COUNT_W - 1;
  localparam int OVF_B  = rms_pkg::MED_W + rms_pkg::COUNT_W;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // every result covers at least one sample
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[CNT_HI:CNT_LO] != '0)
    else $error("result with zero count");

  // a dropped sample only happens with the store full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OVF_B] |->
      out_tdata[CNT_HI:CNT_LO] == rms_pkg::COUNT_W'(rms_pkg::CAPACITY))
    else $error("overflow below capacity");

  // in_tready drops after every accept, so items are never accepted back to back
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("items accepted back to back");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result after reset");

endmodule

bind running_median_stream rms_chk u_rms_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tdata  (in_tdata),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 20000;
  localparam rms_pkg::sample_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam rms_pkg::sample_t SAMPLE_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [rms_pkg::MED_W-1:0] median_twice;
    logic [rms_pkg::COUNT_W-1:0]      count;
    logic                             overflow;
  } median_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [rms_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [rms_pkg::OUT_DATA_W-1:0] out_tdata;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  // sorted copy of the samples of the current sequence
  rms_pkg::sample_t sorted_samples[rms_pkg::CAPACITY];
  int unsigned held = 0;
  median_result_t pending_medians[$];
  median_result_t want, got;

  running_median_stream u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic median_result_t next_median(rms_pkg::sample_t s, logic first);
    median_result_t r;
    int unsigned pos;
    if (first)
      held = 0;
    r.overflow = (held >= rms_pkg::CAPACITY);
    if (!r.overflow) begin
      pos = held;
      while (pos > 0 && sorted_samples[pos-1] > s) begin
        sorted_samples[pos] = sorted_samples[pos-1];
        pos--;
      end
      sorted_samples[pos] = s;
      held++;
    end
    if (held % 2 == 1)
      r.median_twice = {sorted_samples[held/2], 1'b0};
    else
      r.median_twice = rms_pkg::MED_W'(sorted_samples[held/2-1])
                     + rms_pkg::MED_W'(sorted_samples[held/2]);
    r.count = rms_pkg::COUNT_W'(held);
    return r;
  endfunction

  function automatic rms_pkg::sample_t rand_sample(int unsigned kind);
    case (kind)
      0: return rms_pkg::sample_t'(int'($urandom_range(16)) - 8);
      1: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      2: return rms_pkg::sample_t'(int'($urandom_range(2000)) - 1000);
      default: return rms_pkg::sample_t'($urandom);
    endcase
  endfunction

  // in_tvalid stays high after an accept so back-to-back items need one assignment per step
  task automatic send_item(input rms_pkg::sample_t s, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    pending_medians.push_back(next_median(s, first));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_medians.size() > 0)
      @(posedge clk);
  endtask

  task automatic test_extremes();
    // no first flag after reset: store starts empty
    send_item(32'sd5, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(32'sd3, 1'b0);
    send_item(SAMPLE_MAX, 1'b1);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MIN, 1'b1);
    send_item(SAMPLE_MIN, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(SAMPLE_MAX, 1'b0);
    send_item(-32'sd1, 1'b1);
    send_item(32'sd0, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(-32'sd2, 1'b0);
    send_item(32'sh5555_5555, 1'b1);
    send_item(32'shAAAA_AAAA, 1'b0);
    send_item(32'sd7, 1'b1);
  endtask

  task automatic test_random_sequences(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    sent = 0;
    while (sent < n_items) begin
      len  = $urandom_range(40);
      kind = $urandom_range(4);
      // mostly well-formed sequences, a few with stray first flags
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i <= len; i++)
          send_item(rand_sample($urandom_range(3)), $urandom_range(3) == 0);
      end else begin
        send_item(rand_sample(kind), 1'b1);
        for (int i = 0; i < len; i++)
          send_item(rand_sample(kind), 1'b0);
      end
      sent += len + 1;
    end
  endtask

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.median_twice = out_tdata[rms_pkg::MED_W-1:0];
      got.count        = out_tdata[rms_pkg::MED_W +: rms_pkg::COUNT_W];
      got.overflow     = out_tdata[rms_pkg::MED_W+rms_pkg::COUNT_W];
      if (pending_medians.size() == 0) begin
        $display("%0t unexpected item: expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = pending_medians.pop_front();
        if (got.median_twice !== want.median_twice) begin
          $display("%0t median_twice mismatch: expected %0d, actual %0d",
                   $time, want.median_twice, got.median_twice);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t count mismatch: expected %0d, actual %0d",
                   $time, want.count, got.count);
          errors++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t overflow mismatch: expected %0b, actual %0b",
                   $time, want.overflow, got.overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 80;
    test_extremes();
    wait_drained();
    test_random_sequences(180);
    wait_drained();

    send_idle_pct = 80;
    recv_idle_pct = 18;
    test_random_sequences(180);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sequences(170);
    wait_drained();

    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
